FILE: design/rssi_pkg.sv
// ----------------------------------------------------------------------------
// rssi_pkg
// shared types, constants and helpers of the ray / sheet slab intersect block
// ----------------------------------------------------------------------------
`default_nettype none

package rssi_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int HALF_W        = 31;
  localparam int IN_TDATA_W    = 256;
  localparam int OUT_TDATA_W   = 72;

  // pipeline depths
  localparam int XF_LAT   = 3;              // input, products, sums
  localparam int DIV_BITS = 32;             // one quotient bit per stage
  localparam int DIV_LAT  = DIV_BITS + 2;   // prep + bit stages + fix-up
  localparam int CLIP_LAT = 3;
  localparam int LAT      = XF_LAT + DIV_LAT + CLIP_LAT;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAIR_A    = 3'd0,
    CFG_PAIR_B    = 3'd1,
    CFG_PAIR_C    = 3'd2,
    CFG_PAIR_D    = 3'd3,
    CFG_LAST_SH_X = 3'd4,
    CFG_SHIFT_YZ  = 3'd5,
    CFG_HALF_W    = 3'd6,
    CFG_HALF_H    = 3'd7
  } cfg_reg_e;

  // input transfer, origin_x in the lowest bits
  typedef struct packed {
    logic signed [DATA_W-1:0] range_far;
    logic signed [DATA_W-1:0] range_near;
    logic signed [DATA_W-1:0] heading_z;
    logic signed [DATA_W-1:0] heading_y;
    logic signed [DATA_W-1:0] heading_x;
    logic signed [DATA_W-1:0] origin_z;
    logic signed [DATA_W-1:0] origin_y;
    logic signed [DATA_W-1:0] origin_x;
  } ray_t;

  // per-ray range bounds and flags that ride beside the dividers
  typedef struct packed {
    logic signed [DATA_W-1:0] near;
    logic signed [DATA_W-1:0] far;
    logic                     zero_x;
    logic                     zero_y;
    logic                     zero_z;
    logic                     pass_x;
    logic                     pass_y;
    logic                     pass_z;
    logic                     dz_pos;
  } side_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = S32_MAX;
    end else if (v < -66'sh0_8000_0000) begin
      r = S32_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] smax(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [DATA_W-1:0] smin(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

FILE: design/rssi_xform.sv
// ----------------------------------------------------------------------------
// rssi_xform
// three-stage world to local transform of origin and heading
// ----------------------------------------------------------------------------
`default_nettype none

module rssi_xform #(
  parameter int FRAC_BITS = rssi_pkg::FRAC_BITS_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   en_i,
  input  rssi_pkg::ray_t                        ray_i,
  input  wire [8:0][rssi_pkg::DATA_W-1:0]       mat_i,
  input  wire [2:0][rssi_pkg::DATA_W-1:0]       shift_i,
  output logic [2:0][rssi_pkg::DATA_W-1:0]      lp_o,
  output logic [2:0][rssi_pkg::DATA_W-1:0]      ld_o,
  output logic signed [rssi_pkg::DATA_W-1:0]    near_o,
  output logic signed [rssi_pkg::DATA_W-1:0]    far_o
);

  rssi_pkg::ray_t ray_q;
  logic [2:0][rssi_pkg::DATA_W-1:0] wp, wd;
  logic signed [63:0] pp_q [3][3];
  logic signed [63:0] pd_q [3][3];
  logic signed [rssi_pkg::DATA_W-1:0] near1_q, far1_q, near2_q, far2_q;
  logic [2:0][rssi_pkg::DATA_W-1:0] lp_d, ld_d, lp_q, ld_q;

  assign wp[0] = ray_q.origin_x;
  assign wp[1] = ray_q.origin_y;
  assign wp[2] = ray_q.origin_z;
  assign wd[0] = ray_q.heading_x;
  assign wd[1] = ray_q.heading_y;
  assign wd[2] = ray_q.heading_z;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray_q   <= ray_i;
      near1_q <= ray_q.range_near;
      far1_q  <= ray_q.range_far;
      near2_q <= near1_q;
      far2_q  <= far1_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_q[i][j] <= $signed(mat_i[3*j+i]) * $signed(wp[j]);
          pd_q[i][j] <= $signed(mat_i[3*j+i]) * $signed(wd[j]);
        end
      end
      lp_q <= lp_d;
      ld_q <= ld_d;
    end
  end

  // floor shift of each product, exact sum, saturate
  always_comb begin
    logic signed [65:0] sp, sd;
    for (int i = 0; i < 3; i++) begin
      sp = 66'($signed(shift_i[i]));
      sd = '0;
      for (int j = 0; j < 3; j++) begin
        sp = sp + 66'(pp_q[i][j] >>> FRAC_BITS);
        sd = sd + 66'(pd_q[i][j] >>> FRAC_BITS);
      end
      lp_d[i] = rssi_pkg::sat32(sp);
      ld_d[i] = rssi_pkg::sat32(sd);
    end
  end

  assign lp_o   = lp_q;
  assign ld_o   = ld_q;
  assign near_o = near2_q;
  assign far_o  = far2_q;

endmodule

`default_nettype wire

FILE: design/rssi_div.sv
// ----------------------------------------------------------------------------
// rssi_div
// pipelined restoring divider, (diff << FRAC_BITS) / dir, truncating, saturated
// ----------------------------------------------------------------------------
`default_nettype none

module rssi_div #(
  parameter int FRAC_BITS = rssi_pkg::FRAC_BITS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 en_i,
  input  wire signed [33:0]                   diff_i,
  input  wire signed [rssi_pkg::DATA_W-1:0]   dir_i,
  output logic signed [rssi_pkg::DATA_W-1:0]  quot_o
);

  localparam int NUM_W = 34 + FRAC_BITS;
  localparam int NB    = rssi_pkg::DIV_BITS;

  logic [33:0]      diff_mag;
  logic [NUM_W-1:0] num_mag;
  logic [NB-1:0]    dir_mag;
  logic             ovf_d;

  logic [NB-1:0] rem_q [NB+1];
  logic [NB-1:0] low_q [NB+1];
  logic [NB-1:0] quo_q [NB+1];
  logic [NB-1:0] dm_q  [NB+1];
  logic          neg_q [NB+1];
  logic          ovf_q [NB+1];

  logic signed [rssi_pkg::DATA_W-1:0] quot_d, quot_q;

  // magnitudes, sign and overflow (quotient of 2^32 or more)
  always_comb begin
    diff_mag = diff_i[33] ? 34'(-diff_i) : diff_i;
    num_mag  = {diff_mag, {FRAC_BITS{1'b0}}};
    dir_mag  = dir_i[rssi_pkg::DATA_W-1] ? NB'(-dir_i) : dir_i;
    ovf_d    = (NUM_W'(num_mag >> NB)) >= NUM_W'(dir_mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= NB'(num_mag >> NB);
      low_q[0] <= num_mag[NB-1:0];
      quo_q[0] <= '0;
      dm_q[0]  <= dir_mag;
      neg_q[0] <= diff_i[33] ^ dir_i[rssi_pkg::DATA_W-1];
      ovf_q[0] <= ovf_d;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_bit
    logic [NB:0] r2;
    logic        ge;
    assign r2 = {rem_q[k], low_q[k][NB-1]};
    assign ge = r2 >= {1'b0, dm_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? NB'(r2 - {1'b0, dm_q[k]}) : r2[NB-1:0];
        low_q[k+1] <= {low_q[k][NB-2:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][NB-2:0], ge};
        dm_q[k+1]  <= dm_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  // sign and saturation
  always_comb begin
    if (ovf_q[NB]) begin
      quot_d = neg_q[NB] ? rssi_pkg::S32_MIN : rssi_pkg::S32_MAX;
    end else if (neg_q[NB]) begin
      quot_d = (quo_q[NB] > 32'h8000_0000) ? rssi_pkg::S32_MIN : 32'(-quo_q[NB]);
    end else begin
      quot_d = quo_q[NB][NB-1] ? rssi_pkg::S32_MAX : quo_q[NB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

FILE: design/rssi_clip.sv
// ----------------------------------------------------------------------------
// rssi_clip
// three-stage range narrowing and hit decision
// ----------------------------------------------------------------------------
`default_nettype none

module rssi_clip (
  input  wire                                 clk_i,
  input  wire                                 en_i,
  input  rssi_pkg::side_t                     side_i,
  input  wire signed [rssi_pkg::DATA_W-1:0]   tx0_i,
  input  wire signed [rssi_pkg::DATA_W-1:0]   tx1_i,
  input  wire signed [rssi_pkg::DATA_W-1:0]   ty0_i,
  input  wire signed [rssi_pkg::DATA_W-1:0]   ty1_i,
  input  wire signed [rssi_pkg::DATA_W-1:0]   tz_i,
  output logic                                hit_o,
  output logic signed [rssi_pkg::DATA_W-1:0]  enter_o,
  output logic signed [rssi_pkg::DATA_W-1:0]  exit_o
);

  logic signed [rssi_pkg::DATA_W-1:0] near_q, far_q;
  logic signed [rssi_pkg::DATA_W-1:0] xlo_q, xhi_q, ylo_q, yhi_q, zlo_q, zhi_q;
  logic signed [rssi_pkg::DATA_W-1:0] tmin_q, tmax_q;
  logic signed [rssi_pkg::DATA_W-1:0] enter_q, exit_q;
  logic fail_a_q, fail_b_q, hit_q, hit_d;

  // stage a: order each slab's pair, neutral bounds for skipped slabs
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      near_q   <= side_i.near;
      far_q    <= side_i.far;
      fail_a_q <= (side_i.zero_x & ~side_i.pass_x) | (side_i.zero_y & ~side_i.pass_y) |
                  (side_i.zero_z & ~side_i.pass_z);
      xlo_q <= side_i.zero_x ? rssi_pkg::S32_MIN : rssi_pkg::smin(tx0_i, tx1_i);
      xhi_q <= side_i.zero_x ? rssi_pkg::S32_MAX : rssi_pkg::smax(tx0_i, tx1_i);
      ylo_q <= side_i.zero_y ? rssi_pkg::S32_MIN : rssi_pkg::smin(ty0_i, ty1_i);
      yhi_q <= side_i.zero_y ? rssi_pkg::S32_MAX : rssi_pkg::smax(ty0_i, ty1_i);
      zlo_q <= (side_i.zero_z | ~side_i.dz_pos) ? rssi_pkg::S32_MIN : tz_i;
      zhi_q <= (side_i.zero_z | side_i.dz_pos) ? rssi_pkg::S32_MAX : tz_i;
    end
  end

  // stage b: narrowed range
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tmin_q   <= rssi_pkg::smax(rssi_pkg::smax(near_q, xlo_q), rssi_pkg::smax(ylo_q, zlo_q));
      tmax_q   <= rssi_pkg::smin(rssi_pkg::smin(far_q, xhi_q), rssi_pkg::smin(yhi_q, zhi_q));
      fail_b_q <= fail_a_q;
    end
  end

  // stage c: decision
  assign hit_d = ~fail_b_q & (tmin_q <= tmax_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q   <= hit_d;
      enter_q <= hit_d ? tmin_q : rssi_pkg::S32_MAX;
      exit_q  <= hit_d ? tmax_q : rssi_pkg::S32_MAX;
    end
  end

  assign hit_o   = hit_q;
  assign enter_o = enter_q;
  assign exit_o  = exit_q;

endmodule

`default_nettype wire

FILE: design/ray_sheet_slab_intersect.sv
// throughput: one ray per cycle while the master side does not stall; the 32 one-bit divider stages set the depth
// a stall on the master side freezes the whole pipeline, nothing is dropped
// reset (rst_ni low, asynchronous) clears valid bits and all config registers
// ----------------------------------------------------------------------------
// ray_sheet_slab_intersect
// ray against sheet box, world to local transform then slab clipping
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sheet_slab_intersect #(
  parameter int FRAC_BITS = rssi_pkg::FRAC_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // config write port
  input  wire                                  cfg_we_i,
  input  wire [rssi_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire [rssi_pkg::CFG_W-1:0]            cfg_data_i,
  // ray in
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // origin_x, origin_y, origin_z, heading_x, heading_y, heading_z,
  // range_near, range_far (32 bits each, lowest first)
  input  wire [rssi_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // result out
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // hit [0], enter_distance [32:1], exit_distance [64:33], zero fill above
  output logic [rssi_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  localparam int LAT = rssi_pkg::LAT;
  localparam int DL  = rssi_pkg::DIV_LAT;
  localparam int XL  = rssi_pkg::XF_LAT;

  // ---------------------------------------------------------------- config
  logic [rssi_pkg::CFG_W-1:0] pair_a_q, pair_b_q, pair_c_q, pair_d_q;
  logic [rssi_pkg::CFG_W-1:0] last_sh_x_q, shift_yz_q;
  logic [rssi_pkg::HALF_W-1:0] half_w_q, half_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_a_q    <= '0;
      pair_b_q    <= '0;
      pair_c_q    <= '0;
      pair_d_q    <= '0;
      last_sh_x_q <= '0;
      shift_yz_q  <= '0;
      half_w_q    <= '0;
      half_h_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (rssi_pkg::cfg_reg_e'(cfg_idx_i))
        rssi_pkg::CFG_PAIR_A:    pair_a_q    <= cfg_data_i;
        rssi_pkg::CFG_PAIR_B:    pair_b_q    <= cfg_data_i;
        rssi_pkg::CFG_PAIR_C:    pair_c_q    <= cfg_data_i;
        rssi_pkg::CFG_PAIR_D:    pair_d_q    <= cfg_data_i;
        rssi_pkg::CFG_LAST_SH_X: last_sh_x_q <= cfg_data_i;
        rssi_pkg::CFG_SHIFT_YZ:  shift_yz_q  <= cfg_data_i;
        rssi_pkg::CFG_HALF_W:    half_w_q    <= cfg_data_i[rssi_pkg::HALF_W-1:0];
        rssi_pkg::CFG_HALF_H:    half_h_q    <= cfg_data_i[rssi_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // column-major matrix entries, even entry in the low half of each pair
  logic [8:0][rssi_pkg::DATA_W-1:0] mat;
  logic [2:0][rssi_pkg::DATA_W-1:0] shift;

  assign mat[0]   = pair_a_q[31:0];
  assign mat[1]   = pair_a_q[63:32];
  assign mat[2]   = pair_b_q[31:0];
  assign mat[3]   = pair_b_q[63:32];
  assign mat[4]   = pair_c_q[31:0];
  assign mat[5]   = pair_c_q[63:32];
  assign mat[6]   = pair_d_q[31:0];
  assign mat[7]   = pair_d_q[63:32];
  assign mat[8]   = last_sh_x_q[31:0];
  assign shift[0] = last_sh_x_q[63:32];
  assign shift[1] = shift_yz_q[31:0];
  assign shift[2] = shift_yz_q[63:32];

  // ------------------------------------------------------- flow control
  // one enable for every stage; bubbles stay in place while stalled
  logic [LAT-1:0] vld_q;
  logic           en;

  assign en            = ~vld_q[LAT-1] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // ------------------------------------------------------------ transform
  logic [2:0][rssi_pkg::DATA_W-1:0] lp, ld;
  logic signed [rssi_pkg::DATA_W-1:0] near, far;

  rssi_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk_i   (clk_i),
    .en_i    (en),
    .ray_i   (rssi_pkg::ray_t'(s_axis_tdata)),
    .mat_i   (mat),
    .shift_i (shift),
    .lp_o    (lp),
    .ld_o    (ld),
    .near_o  (near),
    .far_o   (far)
  );

  // ---------------------------------------------------- slab differences
  // bound minus local origin, exact in 34 bits
  logic signed [33:0] hw34, hh34, px34, py34, pz34;
  logic signed [33:0] dx0, dx1, dy0, dy1, dz;

  assign hw34 = 34'({1'b0, half_w_q});
  assign hh34 = 34'({1'b0, half_h_q});
  assign px34 = 34'($signed(lp[0]));
  assign py34 = 34'($signed(lp[1]));
  assign pz34 = 34'($signed(lp[2]));
  assign dx0  = -hw34 - px34;
  assign dx1  = hw34 - px34;
  assign dy0  = -hh34 - py34;
  assign dy1  = hh34 - py34;
  assign dz   = -pz34;

  // range bounds, zero-heading, inside-slab and heading-sign flags, carried beside the dividers
  rssi_pkg::side_t side_d;
  rssi_pkg::side_t side_q [DL];

  always_comb begin
    side_d.near   = near;
    side_d.far    = far;
    side_d.zero_x = (ld[0] == '0);
    side_d.zero_y = (ld[1] == '0);
    side_d.zero_z = (ld[2] == '0);
    side_d.pass_x = (px34 >= -hw34) && (px34 <= hw34);
    side_d.pass_y = (py34 >= -hh34) && (py34 <= hh34);
    side_d.pass_z = ~lp[2][rssi_pkg::DATA_W-1];
    side_d.dz_pos = ~ld[2][rssi_pkg::DATA_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < DL; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ------------------------------------------------------------ dividers
  logic signed [rssi_pkg::DATA_W-1:0] tx0, tx1, ty0, ty1, tz;

  rssi_div #(.FRAC_BITS(FRAC_BITS)) u_div_x0 (
    .clk_i(clk_i), .en_i(en), .diff_i(dx0), .dir_i(ld[0]), .quot_o(tx0));
  rssi_div #(.FRAC_BITS(FRAC_BITS)) u_div_x1 (
    .clk_i(clk_i), .en_i(en), .diff_i(dx1), .dir_i(ld[0]), .quot_o(tx1));
  rssi_div #(.FRAC_BITS(FRAC_BITS)) u_div_y0 (
    .clk_i(clk_i), .en_i(en), .diff_i(dy0), .dir_i(ld[1]), .quot_o(ty0));
  rssi_div #(.FRAC_BITS(FRAC_BITS)) u_div_y1 (
    .clk_i(clk_i), .en_i(en), .diff_i(dy1), .dir_i(ld[1]), .quot_o(ty1));
  rssi_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk_i(clk_i), .en_i(en), .diff_i(dz), .dir_i(ld[2]), .quot_o(tz));

  // ------------------------------------------------------------- clipping
  logic hit;
  logic signed [rssi_pkg::DATA_W-1:0] enter_dist, exit_dist;

  rssi_clip u_clip (
    .clk_i   (clk_i),
    .en_i    (en),
    .side_i  (side_q[DL-1]),
    .tx0_i   (tx0),
    .tx1_i   (tx1),
    .ty0_i   (ty0),
    .ty1_i   (ty1),
    .tz_i    (tz),
    .hit_o   (hit),
    .enter_o (enter_dist),
    .exit_o  (exit_dist)
  );

  assign m_axis_tdata = {7'd0, exit_dist, enter_dist, hit};

  // ----------------------------------------------------------- assertions
  // a miss always reports saturated distances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !hit) |-> (enter_dist == rssi_pkg::S32_MAX &&
                                 exit_dist == rssi_pkg::S32_MAX))
    else $error("miss without saturated distances");

  // a hit has a non-empty range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && hit) |-> (enter_dist <= exit_dist))
    else $error("hit with entry beyond exit");

  // the slave side only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // a valid bit at the end of the transform moves on into the next stage when enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[XL-1] && en) |=> vld_q[XL])
    else $error("valid bit lost after transform");

endmodule

`default_nettype wire
